FILE: rtl/dh_pkg.sv
`default_nettype none

package dh_pkg;

    localparam int DUR_W       = 48;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int WIDTH_W     = 32;
    localparam int NBKT_W      = 6;
    localparam int IDX_OUT_W   = 6;
    localparam int COUNT_OUT_W = 32;
    localparam int SHARE_W     = 17;
    localparam int TOTAL_OUT_W = 38;
    localparam int FRAC_BITS   = 16;
    localparam int STEP_W      = $clog2(DUR_W + 1);

    localparam int DEF_MAX_BUCKETS = 32;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_WIDTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKETS_IN_USE = 1'd1;

    localparam logic [WIDTH_W-1:0] RST_BUCKET_WIDTH = 32'd1000000;
    localparam logic [NBKT_W-1:0]  RST_BUCKETS      = 6'd32;

    localparam logic [STEP_W-1:0] REC_STEPS   = STEP_W'(DUR_W);
    localparam logic [STEP_W-1:0] SHARE_STEPS = STEP_W'(FRAC_BITS + 1);

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [SHARE_W-1:0] quot;
        logic               over;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: rtl/dh_div.sv
`default_nettype none

module dh_div
    import dh_pkg::*;
#(
    parameter int DV_W = 55
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    input  wire logic [DV_W-1:0]  i_rem_init,
    input  wire logic [DUR_W-1:0] i_dividend,
    input  wire logic [DV_W-1:0]  i_divisor,
    output t_div_rsp              o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DV_W-1:0]   r_rem;
    logic [DV_W-1:0]   r_div;
    logic [DUR_W-1:0]  r_dvd;
    logic [SHARE_W-1:0] r_q;
    logic              r_over;

    logic [DV_W:0]   trial;
    logic [DV_W+1:0] diff;
    logic            qbit;
    logic [DV_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DUR_W-1]};
        diff  = {1'b0, trial} - {2'b0, r_div};
        qbit  = ~diff[DV_W+1];
        n_rem = qbit ? diff[DV_W-1:0] : trial[DV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_rem_init;
            r_div  <= i_divisor;
            r_dvd  <= i_dividend;
            r_q    <= '0;
            r_over <= 1'b0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_dvd  <= {r_dvd[DUR_W-2:0], 1'b0};
            r_q    <= {r_q[SHARE_W-2:0], qbit};
            r_over <= r_over | r_q[SHARE_W-1];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.over = r_over;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

FILE: rtl/dh_mem.sv
`default_nettype none

module dh_mem
    import dh_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int W     = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_clr,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [W-1:0]     r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[i_raddr];
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

FILE: rtl/duration_histogram_unit.sv
// Duration histogram with equal-width buckets.
// Input channel (i_valid / o_stall): one beat carries i_cmd and i_duration_ns.
// Record places the duration in bucket ceil(d/width)-1, clamped to the last
// bucket in use; report streams one output beat per bucket in use with count,
// total, Q1.16 share and o_last_flag on the final bucket; clear zeroes all
// counters at once. Output channel: o_valid / i_stall.
// Configuration: i_cfg_we writes register i_cfg_idx (0 bucket width,
// 1 buckets in use) with i_cfg_data; write only while the unit is idle.
// Operation: one beat is worked on at a time and o_stall is high meanwhile.
// A record runs the 48-step shared restoring divider; a zero duration or
// zero width skips it.
// A report first reads and adds the counter of each bucket to form the total,
// then per bucket reads the counter, runs 17 divider steps (skipped when the
// total is zero) and sends one output beat.
// Clear and unknown commands are done while idle, without raising o_stall.
// A stalled output beat holds its fields until taken; no new input is taken.
// Reset (synchronous, active low) restores the configuration and state registers and clears every
// counter at once through per-entry valid bits; no clearing pass is needed.
`default_nettype none

module duration_histogram_unit
    import dh_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [CMD_W-1:0]       i_cmd,
    input  wire logic [DUR_W-1:0]       i_duration_ns,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic      [IDX_OUT_W-1:0]   o_bucket_index,
    output logic      [COUNT_OUT_W-1:0] o_bucket_count,
    output logic      [SHARE_W-1:0]     o_share_q16,
    output logic      [TOTAL_OUT_W-1:0] o_total_count,
    output logic                        o_last_flag
);

    localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int N_W   = $clog2(MAX_BUCKETS + 1);
    localparam int TOT_W = COUNT_WIDTH + N_W;
    localparam int DV_W  = (TOT_W > WIDTH_W) ? TOT_W : WIDTH_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_REC_DIV = 4'd1;
    localparam logic [3:0] S_REC_RD  = 4'd2;
    localparam logic [3:0] S_REC_WR  = 4'd3;
    localparam logic [3:0] S_SUM_RD  = 4'd4;
    localparam logic [3:0] S_SUM_ACC = 4'd5;
    localparam logic [3:0] S_REP_RD  = 4'd6;
    localparam logic [3:0] S_REP_CAP = 4'd7;
    localparam logic [3:0] S_REP_DIV = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]             r_state, n_state;
    logic [WIDTH_W-1:0]     r_width;
    logic [NBKT_W-1:0]      r_nbkt;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [TOT_W-1:0]       r_total, n_total;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [SHARE_W-1:0]     r_share, n_share;

    logic [7:0]             nb_ext;
    logic [7:0]             nb_sel;
    logic [N_W-1:0]         n_act;
    logic [IDX_W-1:0]       nm1;
    logic                   in_acc;
    logic                   is_last;
    logic                   clamp;

    t_div_req               div_req;
    t_div_rsp               div_rsp;
    logic [DV_W-1:0]        div_rem_init;
    logic [DUR_W-1:0]       div_dividend;
    logic [DV_W-1:0]        div_divisor;

    logic                   mem_clr;
    logic                   mem_we;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [COUNT_WIDTH-1:0] mem_rdata;

    always_comb begin
        nb_ext = {2'b00, r_nbkt};
        if (nb_ext == 8'd0) begin
            nb_sel = 8'd1;
        end else if (nb_ext > 8'(MAX_BUCKETS)) begin
            nb_sel = 8'(MAX_BUCKETS);
        end else begin
            nb_sel = nb_ext;
        end
        n_act = nb_sel[N_W-1:0];
    end

    assign nm1     = IDX_W'(n_act - 1'b1);
    assign is_last = (r_idx == nm1);
    assign in_acc  = i_valid & ~o_stall;
    assign clamp   = div_rsp.over | (div_rsp.quot >= SHARE_W'(n_act));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= RST_BUCKET_WIDTH;
            r_nbkt  <= RST_BUCKETS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BUCKET_WIDTH:   r_width <= i_cfg_data[WIDTH_W-1:0];
                REG_BUCKETS_IN_USE: r_nbkt  <= i_cfg_data[NBKT_W-1:0];
                default:            r_nbkt  <= r_nbkt;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_total      = r_total;
        n_cnt        = r_cnt;
        n_share      = r_share;
        div_req      = '0;
        div_rem_init = '0;
        div_dividend = i_duration_ns - 1'b1;
        div_divisor  = DV_W'(r_width);
        mem_clr      = 1'b0;
        mem_we       = 1'b0;
        mem_wdata    = (&mem_rdata) ? mem_rdata : mem_rdata + 1'b1;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_cmd)
                        CMD_RECORD: begin
                            if (i_duration_ns == '0) begin
                                n_idx   = '0;
                                n_state = S_REC_RD;
                            end else if (r_width == '0) begin
                                n_idx   = nm1;
                                n_state = S_REC_RD;
                            end else begin
                                div_req.start = 1'b1;
                                div_req.steps = REC_STEPS;
                                n_state       = S_REC_DIV;
                            end
                        end
                        CMD_REPORT: begin
                            n_idx   = '0;
                            n_total = '0;
                            n_state = S_SUM_RD;
                        end
                        CMD_CLEAR: mem_clr = 1'b1;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_REC_DIV: begin
                if (div_rsp.done) begin
                    n_idx   = clamp ? nm1 : div_rsp.quot[IDX_W-1:0];
                    n_state = S_REC_RD;
                end
            end
            S_REC_RD: n_state = S_REC_WR;
            S_REC_WR: begin
                mem_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_SUM_RD: n_state = S_SUM_ACC;
            S_SUM_ACC: begin
                n_total = r_total + TOT_W'(mem_rdata);
                if (is_last) begin
                    n_idx   = '0;
                    n_state = S_REP_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SUM_RD;
                end
            end
            S_REP_RD: n_state = S_REP_CAP;
            S_REP_CAP: begin
                n_cnt = mem_rdata;
                if (r_total == '0) begin
                    n_share = '0;
                    n_state = S_OUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.steps = SHARE_STEPS;
                    div_rem_init  = DV_W'(mem_rdata >> 1);
                    div_dividend  = {mem_rdata[0], {(DUR_W-1){1'b0}}};
                    div_divisor   = DV_W'(r_total);
                    n_state       = S_REP_DIV;
                end
            end
            S_REP_DIV: begin
                if (div_rsp.done) begin
                    n_share = div_rsp.quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_REP_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_cnt   <= n_cnt;
        r_share <= n_share;
    end

    dh_div #(
        .DV_W (DV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_rem_init (div_rem_init),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_rsp      (div_rsp)
    );

    dh_mem #(
        .DEPTH (MAX_BUCKETS),
        .W     (COUNT_WIDTH),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mem_clr),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_bucket_index = IDX_OUT_W'(r_idx);
    assign o_bucket_count = COUNT_OUT_W'(r_cnt);
    assign o_share_q16    = r_share;
    assign o_total_count  = TOTAL_OUT_W'(r_total);
    assign o_last_flag    = is_last;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_REC_DIV || r_state == S_REP_DIV))
        else $error("divider result outside a wait state");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_REC_DIV) |-> (r_idx <= nm1))
        else $error("bucket index beyond buckets in use");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_flag && !i_stall) |=> (r_state == S_IDLE))
        else $error("report did not end after last beat");

    a_share_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_share_q16 <= SHARE_W'(1 << FRAC_BITS)))
        else $error("share above one");

endmodule

`default_nettype wire
